### sv/sqi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqi_pkg
// Shared field widths and codes of the iterative square root block.
// ----------------------------------------------------------------------------
package sqi_pkg;

  localparam int VALUE_W   = 32;
  localparam int ROOT_W    = 25;
  localparam int ITER_W    = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_METHOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL    = 1'b1;

  localparam logic METHOD_BISECT = 1'b0;
  localparam logic METHOD_NEWTON = 1'b1;

  localparam logic [VALUE_W-1:0] TOL_RESET = 32'd6554;

endpackage

### sv/square_root_iterative_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_root_iterative_top
// Fixed-point square root by bisection or Newton-Raphson refinement.
// ----------------------------------------------------------------------------
// Steps: the integer root is found digit by digit in ST_ROOT, ST_INIT seeds
// the estimate, then ST_MUL squares it and ST_CHK checks it and takes a
// bisection step; a Newton step adds a bit-serial divide in ST_DIV; ST_FIN
// writes the output register. One item at a time: in_tready only in ST_IDLE.
// Reset: synchronous active-low; method returns to bisection and tolerance
// to 6554, the output register is emptied.
module square_root_iterative_top #(
  parameter int MAX_ITER  = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [sqi_pkg::VALUE_W-1:0] in_tdata,   // value[31:0]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [31:0]                 out_tdata,  // root[24:0], iterations[31:25]
  output logic                        out_tuser,  // converged[0]
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sqi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                 cfg_data
);

  import sqi_pkg::*;

  localparam int MW  = VALUE_W - FRAC_BITS;
  localparam int NW  = (MW + 1) / 2;
  localparam int XW  = 16 + FRAC_BITS / 2 + 2;
  localparam int PW  = 2 * XW;
  localparam int SCW = $clog2(NW + 1);
  localparam int IW  = (MAX_ITER < 2) ? 1 : $clog2(MAX_ITER + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ROOT = 3'd1;
  localparam logic [2:0] ST_INIT = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_CHK  = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic               method_r, method_nxt;
  logic [VALUE_W-1:0] tol_r, tol_nxt;
  logic [VALUE_W-1:0] v_r, v_nxt;
  logic               meth_r, meth_nxt;
  logic [2*NW-1:0]    msh_r, msh_nxt;
  logic [NW-1:0]      sroot_r, sroot_nxt;
  logic [NW+1:0]      srem_r, srem_nxt;
  logic [SCW-1:0]     scnt_r, scnt_nxt;
  logic [XW-1:0]      x_r, x_nxt;
  logic [XW-1:0]      a_r, a_nxt;
  logic [XW-1:0]      b_r, b_nxt;
  logic [PW-1:0]      xx_r, xx_nxt;
  logic               ge_r, ge_nxt;
  logic [IW-1:0]      it_r, it_nxt;
  logic               conv_r, conv_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic [ROOT_W-1:0]  oroot_r, oroot_nxt;
  logic [ITER_W-1:0]  oiter_r, oiter_nxt;
  logic               oconv_r, oconv_nxt;

  logic [NW+1:0] rem_sh, trial;
  logic [PW-1:0] v2, tol2, diff, div_q;
  logic          ge, div_start, div_done;
  logic [XW:0]   bsum;
  logic [XW-1:0] na, nb;

  sqi_div #(.W(PW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (diff),
    .divisor  (PW'(x_r) << 1),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt  = state_r;
    method_nxt = method_r;
    tol_nxt    = tol_r;
    v_nxt      = v_r;
    meth_nxt   = meth_r;
    msh_nxt    = msh_r;
    sroot_nxt  = sroot_r;
    srem_nxt   = srem_r;
    scnt_nxt   = scnt_r;
    x_nxt      = x_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    xx_nxt     = xx_r;
    ge_nxt     = ge_r;
    it_nxt     = it_r;
    conv_nxt   = conv_r;
    ovalid_nxt = ovalid_r;
    oroot_nxt  = oroot_r;
    oiter_nxt  = oiter_r;
    oconv_nxt  = oconv_r;
    div_start  = 1'b0;

    rem_sh = {srem_r[NW-1:0], msh_r[2*NW-1 -: 2]};
    trial  = {sroot_r, 2'b01};
    v2     = PW'(v_r) << FRAC_BITS;
    tol2   = PW'(tol_r) << FRAC_BITS;
    ge     = (xx_r >= v2);
    diff   = ge ? (xx_r - v2) : (v2 - xx_r);
    na     = ge ? a_r : x_r;
    nb     = ge ? x_r : b_r;
    bsum   = (XW + 1)'(na) + (XW + 1)'(nb);

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_METHOD: method_nxt = cfg_data[0];
        CFG_TOL:    tol_nxt    = cfg_data;
        default:    ;
      endcase
    end

    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          v_nxt     = in_tdata;
          meth_nxt  = method_r;
          msh_nxt   = (2*NW)'(in_tdata >> FRAC_BITS);
          sroot_nxt = '0;
          srem_nxt  = '0;
          scnt_nxt  = '0;
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (rem_sh >= trial) begin
          srem_nxt  = rem_sh - trial;
          sroot_nxt = {sroot_r[NW-2:0], 1'b1};
        end else begin
          srem_nxt  = rem_sh;
          sroot_nxt = {sroot_r[NW-2:0], 1'b0};
        end
        msh_nxt  = msh_r << 2;
        scnt_nxt = scnt_r + 1'b1;
        if (scnt_r == SCW'(NW - 1)) state_nxt = ST_INIT;
      end
      ST_INIT: begin
        it_nxt = '0;
        a_nxt  = XW'(sroot_r) << FRAC_BITS;
        b_nxt  = (XW'(sroot_r) + 1'b1) << FRAC_BITS;
        if (meth_r == METHOD_BISECT) begin
          if (srem_r == '0 && v_r[FRAC_BITS-1:0] == '0) begin
            x_nxt = XW'(sroot_r) << FRAC_BITS;
          end else begin
            x_nxt = (XW'(sroot_r) << FRAC_BITS) | (XW'(1) << (FRAC_BITS - 1));
          end
        end else if (v_r != '0 && v_r[VALUE_W-1:FRAC_BITS] == '0) begin
          x_nxt = XW'(1) << FRAC_BITS;
        end else begin
          x_nxt = XW'(sroot_r) << FRAC_BITS;
        end
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        xx_nxt    = x_r * x_r;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        ge_nxt = ge;
        if (diff <= tol2) begin
          conv_nxt  = 1'b1;
          state_nxt = ST_FIN;
        end else if (it_r >= IW'(MAX_ITER)) begin
          conv_nxt  = 1'b0;
          state_nxt = ST_FIN;
        end else if (meth_r == METHOD_BISECT) begin
          a_nxt     = na;
          b_nxt     = nb;
          x_nxt     = bsum[XW:1];
          it_nxt    = it_r + 1'b1;
          state_nxt = ST_MUL;
        end else if (x_r == '0) begin
          it_nxt    = it_r + 1'b1;
          state_nxt = ST_MUL;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (ge_r) begin
            x_nxt = (div_q <= PW'(x_r)) ? (x_r - div_q[XW-1:0]) : '0;
          end else begin
            x_nxt = XW'(PW'(x_r) + div_q);
          end
          it_nxt    = it_r + 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_FIN: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          oroot_nxt  = ROOT_W'(x_r);
          oiter_nxt  = ITER_W'(it_r);
          oconv_nxt  = conv_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      method_r <= METHOD_BISECT;
      tol_r    <= TOL_RESET;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      method_r <= method_nxt;
      tol_r    <= tol_nxt;
      ovalid_r <= ovalid_nxt;
    end
    v_r     <= v_nxt;
    meth_r  <= meth_nxt;
    msh_r   <= msh_nxt;
    sroot_r <= sroot_nxt;
    srem_r  <= srem_nxt;
    scnt_r  <= scnt_nxt;
    x_r     <= x_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    xx_r    <= xx_nxt;
    ge_r    <= ge_nxt;
    it_r    <= it_nxt;
    conv_r  <= conv_nxt;
    oroot_r <= oroot_nxt;
    oiter_r <= oiter_nxt;
    oconv_r <= oconv_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {oiter_r, oroot_r};
  assign out_tuser  = oconv_r;

endmodule

### sv/sqi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqi_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sqi_div #(
  parameter int W = 52
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CW = $clog2(W + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W:0]    rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  dsr_r, dsr_nxt;
  logic [W:0]    shifted;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    shifted  = {rem_r[W-1:0], quo_r[W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      if (shifted >= {1'b0, dsr_r}) begin
        rem_nxt = shifted - {1'b0, dsr_r};
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### sv/sqi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqi_checker
// Port-level assertions for the iterative square root block.
// ----------------------------------------------------------------------------
module sqi_checker #(
  parameter int MAX_ITER = 64
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [31:0]                   out_tdata,
  input logic                          out_tuser
);

  import sqi_pkg::*;

  localparam logic [31:0] MAX_ITER_W = 32'(MAX_ITER);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result item changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in progress");

  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      out_tdata[ROOT_W +: ITER_W] == MAX_ITER_W[ITER_W-1:0])
    else $error("unconverged result without full iteration count");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result item valid after reset");

endmodule

bind square_root_iterative_top sqi_checker #(.MAX_ITER(MAX_ITER)) u_sqi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
